// ===== rtl/core/rle_sprite_stream_validator_top_defines.svh =====
// Assertion macros shared by the sprite stream validator RTL.
// Depends on nothing; each user supplies clk and rst_n in its own scope.
`ifndef RLE_SPRITE_STREAM_VALIDATOR_TOP_DEFINES_SVH
`define RLE_SPRITE_STREAM_VALIDATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RSSV_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RSSV_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rssv_pkg.sv =====
// Package for the RLE sprite stream validator: field widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps

package rssv_pkg;

    localparam int WordW  = 16;
    localparam int CountW = 15;

    localparam logic [WordW-1:0]  RUN_FLAG   = 16'h8000;
    localparam logic [CountW-1:0] COUNT_ZERO = '0;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_LEAD    = 3'd1,
        PH_COLORED = 3'd2,
        PH_SKIP    = 3'd3,
        PH_TRANS   = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [WordW-1:0]  word;
        logic [CountW-1:0] row_count;
        logic              is_last;
    } item_t;

endpackage

// ===== rtl/core/rssv_if.sv =====
// Stream channel interfaces for the sprite validator: word input and result output.
// Depends on rssv_pkg.
`timescale 1ns / 1ps

interface rssv_in_if
    import rssv_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WordW-1:0]  word;
    logic [CountW-1:0] row_count;
    logic              is_last;

    modport source (output valid, output word, output row_count, output is_last,
                    input ready);
    modport sink   (input valid, input word, input row_count, input is_last,
                    output ready);
endinterface

interface rssv_out_if;
    logic valid;
    logic ready;
    logic valid_res;

    modport source (output valid, output valid_res, input ready);
    modport sink   (input valid, input valid_res, output ready);
endinterface

// ===== rtl/core/rssv_walker.sv =====
// Row/group walker: holds the parse state and steps it by one word.
// Depends on rssv_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "rle_sprite_stream_validator_top_defines.svh"

module rssv_walker
    import rssv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    output logic  res_ok
);

    phase_t            phase_reg, phase_next;
    logic [CountW-1:0] rows_left_reg, rows_left_next;
    logic [CountW-1:0] skip_left_reg, skip_left_next;
    logic              failed_reg, failed_next;

    phase_t            ph;
    logic [CountW-1:0] rows;
    logic [CountW-1:0] skip;
    logic              fail;
    logic [WordW-1:0]  count_word;

    always_comb
    begin
        ph         = phase_reg;
        rows       = rows_left_reg;
        skip       = skip_left_reg;
        fail       = failed_reg;
        count_word = item.word & ~RUN_FLAG;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.row_count == COUNT_ZERO)
                begin
                    ph   = PH_DONE;
                    fail = 1'b1;
                end
                else
                begin
                    rows = item.row_count;
                    ph   = PH_COLORED;
                end
            end
            PH_LEAD:
            begin
                ph = PH_COLORED;
            end
            PH_COLORED:
            begin
                skip = count_word[CountW-1:0];
                ph   = (skip != COUNT_ZERO) ? PH_SKIP : PH_TRANS;
            end
            PH_SKIP:
            begin
                skip = skip_left_reg - CountW'(1);
                if (skip == COUNT_ZERO)
                    ph = PH_TRANS;
            end
            PH_TRANS:
            begin
                if (item.word == '0)
                begin
                    rows = rows_left_reg - CountW'(1);
                    ph   = (rows == COUNT_ZERO) ? PH_DONE : PH_LEAD;
                end
                else
                begin
                    ph = PH_COLORED;
                end
            end
            default:
            begin
                // closed image: any further word is a leftover
                fail = 1'b1;
            end
        endcase

        res_ok = (ph == PH_DONE) && !fail;

        if (item.is_last)
        begin
            phase_next     = PH_IDLE;
            rows_left_next = COUNT_ZERO;
            skip_left_next = COUNT_ZERO;
            failed_next    = 1'b0;
        end
        else
        begin
            phase_next     = ph;
            rows_left_next = rows;
            skip_left_next = skip;
            failed_next    = fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            rows_left_reg <= COUNT_ZERO;
            skip_left_reg <= COUNT_ZERO;
            failed_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            rows_left_reg <= rows_left_next;
            skip_left_reg <= skip_left_next;
            failed_reg    <= failed_next;
        end
    end

    `RSSV_ASSERT_NXT(a_last_clears, step && item.is_last,
        phase_reg == PH_IDLE && rows_left_reg == COUNT_ZERO && !failed_reg,
        "state not cleared after last word")
    `RSSV_ASSERT_IMP(a_fail_only_done, failed_reg, phase_reg == PH_DONE,
        "failed flag set outside closed phase")
    `RSSV_ASSERT_IMP(a_skip_nonzero, phase_reg == PH_SKIP, skip_left_reg != COUNT_ZERO,
        "skipping with zero pixels left")

endmodule

// ===== rtl/core/rle_sprite_stream_validator_top.sv =====
// Top level of the RLE sprite stream validator: input register, walker, result register.
// Depends on rssv_pkg, rssv_if, rssv_walker and the assertion macro header.
`timescale 1ns / 1ps
`include "rle_sprite_stream_validator_top_defines.svh"

// Usage:
//   words   : sink channel, one 16-bit encoded sprite word per item, plus the
//             image height (row_count, looked at only on the first word of an
//             image) and is_last, which marks the final word of the image.
//   results : source channel, one item per image, issued for the word with
//             is_last set; valid_res is 1 when every row closed exactly there.
// Throughput: one word per cycle unless a last word waits for a busy result
//   slot. Each word only needs a constant update of the row/pixel counters,
//   done in a single combinational pass between the input register and the
//   walker state / result register. A last word in the input register is
//   checked once the result slot is free, and its result is then registered.
// Reset: rst_n (async, active low) empties both registers and returns the
//   walker to "awaiting first word of image". After every last word the
//   walker also returns there, so the next word begins a new image.
// Stall: while a result waits on results.ready, non-last words keep flowing;
//   a second last word waits in the input register, and words.ready drops
//   only when that register is full and cannot move on.

module rle_sprite_stream_validator_top
    import rssv_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    rssv_in_if.sink    words,
    rssv_out_if.source results
);

    item_t item_reg;
    logic  item_valid_reg;
    logic  res_valid_reg, res_valid_next;
    logic  res_reg;

    logic  out_free;
    logic  adv;
    logic  take;
    logic  res_ok;

    // A last word needs a free result slot; other words always advance.
    assign out_free = !res_valid_reg || results.ready;
    assign adv      = item_valid_reg && (!item_reg.is_last || out_free);
    assign take     = words.valid && words.ready;

    assign words.ready       = !item_valid_reg || adv;
    assign results.valid     = res_valid_reg;
    assign results.valid_res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (words.ready)
            item_valid_reg <= words.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.word      <= words.word;
            item_reg.row_count <= words.row_count;
            item_reg.is_last   <= words.is_last;
        end
    end

    rssv_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (adv),
        .item   (item_reg),
        .res_ok (res_ok)
    );

    always_comb
    begin
        if (adv && item_reg.is_last)
            res_valid_next = 1'b1;
        else if (results.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv && item_reg.is_last)
            res_reg <= res_ok;
    end

    `RSSV_ASSERT_IMP(a_take_needs_room, take && item_valid_reg, adv,
        "word taken while input register is held")
    `RSSV_ASSERT_NXT(a_last_gives_result, adv && item_reg.is_last, res_valid_reg,
        "last word produced no result")
    `RSSV_ASSERT_IMP(a_empty_ready, !item_valid_reg, words.ready,
        "input not ready with empty register")

endmodule

// ===== tb/rle_sprite_stream_validator_top_tb.sv =====
// Testbench for the RLE sprite stream validator: directed and random sprite images,
// checked against an in-bench tracker. Depends on rssv_pkg, rssv_if and the top level.
`timescale 1ns / 1ps

module rle_sprite_stream_validator_top_tb;
    import rssv_pkg::*;

    localparam int RANDOM_WORDS  = 1300;
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off for back-pressure
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake before giving up

    logic clk = 1'b0;
    logic rst_n;

    rssv_in_if  words_if ();
    rssv_out_if results_if ();

    rle_sprite_stream_validator_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (words_if),
        .results (results_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shape tracker: follows the row / group structure word by word and
    // queues the verdict owed for every last word.
    // ------------------------------------------------------------------
    phase_t            walk_phase;
    logic [CountW-1:0] rows_open;
    logic [CountW-1:0] pixels_left;
    logic              overrun;      // words seen after every row closed
    logic              verdict_q[$];

    int err_cnt    = 0;
    int words_sent = 0;
    bit no_idle    = 1'b0;           // both sides run without gaps while set

    // receiver control
    int hold_cnt  = 0;
    bit hold_req  = 1'b0;
    int stall_cnt = 0;

    // scratch image built by the tests
    logic [WordW-1:0] img_words[$];

    task automatic clear_tracker();
        walk_phase  = PH_IDLE;
        rows_open   = COUNT_ZERO;
        pixels_left = COUNT_ZERO;
        overrun     = 1'b0;
    endtask

    task automatic track_word(input logic [WordW-1:0] w, input logic [CountW-1:0] rc,
                              input logic last);
        case (walk_phase)
            PH_IDLE:
            begin
                // height only matters on the first word; zero rows means that
                // first word is already one too many
                if (rc == COUNT_ZERO)
                begin
                    walk_phase = PH_DONE;
                    overrun    = 1'b1;
                end
                else
                begin
                    rows_open  = rc;
                    walk_phase = PH_COLORED;
                end
            end
            PH_LEAD:
                walk_phase = PH_COLORED;
            PH_COLORED:
            begin
                pixels_left = CountW'(w & ~RUN_FLAG);
                walk_phase  = (pixels_left != COUNT_ZERO) ? PH_SKIP : PH_TRANS;
            end
            PH_SKIP:
            begin
                pixels_left = pixels_left - 1'b1;
                if (pixels_left == COUNT_ZERO)
                    walk_phase = PH_TRANS;
            end
            PH_TRANS:
            begin
                if (w == '0)
                begin
                    rows_open  = rows_open - 1'b1;
                    walk_phase = (rows_open == COUNT_ZERO) ? PH_DONE : PH_LEAD;
                end
                else
                    walk_phase = PH_COLORED;
            end
            default:
                overrun = 1'b1;
        endcase

        if (last)
        begin
            verdict_q.push_back(walk_phase == PH_DONE && !overrun);
            clear_tracker();
        end
    endtask

    // ------------------------------------------------------------------
    // Word sender. Entered and left at a falling edge with no drive yet in
    // that step, so valid is never lowered and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_word(input logic [WordW-1:0] w, input logic [CountW-1:0] rc,
                             input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            words_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        words_if.valid     <= 1'b1;
        words_if.word      <= w;
        words_if.row_count <= rc;
        words_if.is_last   <= last;
        do
            @(posedge clk);
        while (!(words_if.valid && words_if.ready));
        track_word(w, rc, last);
        words_sent++;
        @(negedge clk);
    endtask

    // Sends img_words as one image: height on the first word, noise on the rest.
    task automatic send_image(input logic [CountW-1:0] rc);
        for (int i = 0; i < img_words.size(); i++)
            send_word(img_words[i], (i == 0) ? rc : CountW'($urandom),
                      i == img_words.size() - 1);
    endtask

    // Drops valid, waits for every owed verdict, then lets the pipe settle.
    task automatic settle();
        words_if.valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One row: leading run, groups of colored count + pixels + transparent run,
    // the last transparent run being the zero that closes the row.
    function automatic void add_row(input int groups);
        int count;
        img_words.push_back(WordW'($urandom));
        for (int g = 0; g < groups; g++)
        begin
            count = $urandom_range(0, 4);
            img_words.push_back({1'($urandom), CountW'(count)});
            repeat (count) img_words.push_back(WordW'($urandom));
            img_words.push_back((g == groups - 1) ? WordW'(0)
                                                  : WordW'($urandom_range(1, 65535)));
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready goes low for a drawn number of cycles after each
    // result, or for a long hold when a test asks for one.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic rdy;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rdy = 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES - 1;
            rdy      = 1'b0;
        end
        else if (stall_cnt > 0)
        begin
            stall_cnt--;
            rdy = 1'b0;
        end
        else
            rdy = 1'b1;
        results_if.ready <= rdy;
    end

    // Verdict checker
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result: valid_res %0b with nothing pending",
                       results_if.valid_res);
                err_cnt++;
            end
            else
            begin
                logic owed;
                owed = verdict_q.pop_front();
                if (results_if.valid_res !== owed)
                begin
                    $error("valid_res mismatch: expected %0b, actual %0b",
                           owed, results_if.valid_res);
                    err_cnt++;
                end
            end
            stall_cnt = no_idle ? 0 : $urandom_range(0, 17);
        end
    end

    // Watchdog: any handshake on either side restarts the count.
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((words_if.valid && words_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One-row images that close exactly at the last word; bit 15 of the
    // colored count is ignored.
    task automatic test_minimal_images();
        img_words = '{16'h0000, 16'h0000, 16'h0000};
        send_image(15'd1);
        img_words = '{16'hFFFF, 16'h8000, 16'h0000};
        send_image(15'd1);
        settle();
    endtask

    // Height zero: the first word is already left over.
    task automatic test_zero_rows();
        img_words = '{16'h1234};
        send_image(COUNT_ZERO);
        settle();
    endtask

    // Images that run out of words before all rows close.
    task automatic test_short_images();
        img_words = '{16'hFFFF};
        send_image(15'd5);
        img_words = '{16'h0000, 16'h0000, 16'h0000};
        send_image(15'd2);
        img_words = '{16'h0000, 16'h0000, 16'h0000};
        send_image(15'h7FFF);
        settle();
    endtask

    // A word after the final row has closed.
    task automatic test_leftover_words();
        img_words = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
        send_image(15'd1);
        settle();
    endtask

    // Last word inside the pixel words, then a masked count that fits.
    task automatic test_pixel_overrun();
        img_words = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
        send_image(15'd1);
        img_words = '{16'h0000, 16'h8002, 16'hFFFF, 16'h0000, 16'h0000};
        send_image(15'd1);
        settle();
    endtask

    // Receiver holds off while the sender keeps offering single-word images,
    // so results back up and the input channel stalls.
    task automatic test_backpressure();
        hold_req = 1'b1;
        wait (hold_cnt > 0);
        no_idle = 1'b1;
        repeat (24)
            send_word(WordW'($urandom), CountW'($urandom_range(0, 1)), 1'b1);
        no_idle = 1'b0;
        settle();
    endtask

    // Mostly well-formed images with random content; some truncated, padded,
    // with the wrong height or a corrupted word.
    task automatic test_random_images();
        int start;
        int rows;
        int cut;
        logic [CountW-1:0] rc;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 7) == 0)
                no_idle = ~no_idle;
            img_words.delete();
            rows = $urandom_range(1, 4);
            repeat (rows) add_row($urandom_range(1, 3));
            rc = CountW'(rows);
            case ($urandom_range(0, 9))
                7:
                begin
                    cut = $urandom_range(1, img_words.size() - 1);
                    repeat (cut) void'(img_words.pop_back());
                end
                8:
                    repeat ($urandom_range(1, 3)) img_words.push_back(WordW'($urandom));
                9:
                begin
                    case ($urandom_range(0, 3))
                        0: rc = rc + 1'b1;
                        1: rc = rc - 1'b1;
                        2: img_words[$urandom_range(0, img_words.size() - 1)] =
                               WordW'($urandom);
                        default: rc = CountW'($urandom_range(1, 32767));
                    endcase
                end
                default: ;
            endcase
            send_image(rc);
        end
        no_idle = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        words_if.valid      = 1'b0;
        words_if.word       = '0;
        words_if.row_count  = '0;
        words_if.is_last    = 1'b0;
        results_if.ready    = 1'b0;
        clear_tracker();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_minimal_images();
        test_zero_rows();
        test_short_images();
        test_leftover_words();
        test_pixel_overrun();
        test_backpressure();
        test_random_images();

        repeat (8) @(negedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d verdicts never arrived", verdict_q.size());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
